### hw/rtl/bole_pkg.sv
// shared types and command codes for the bounded ordered list engine
package bole_pkg;

  typedef enum logic [3:0] {
    OP_INSERT   = 4'd0,
    OP_REMOVE   = 4'd1,
    OP_REPLACE  = 4'd2,
    OP_SELECT   = 4'd3,
    OP_SEARCH   = 4'd4,
    OP_SINS_ASC = 4'd5,
    OP_SINS_DSC = 4'd6,
    OP_SORT_ASC = 4'd7,
    OP_SORT_DSC = 4'd8
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SORT = 4'b0010,
    ST_SRCH = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam int unsigned OpW    = 4;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned TdInW  = 48;
  localparam int unsigned TdOutW = 48;

  // per-cell control from the sequencer
  typedef struct packed {
    logic ins;       // take left neighbor, own cell gets value at pos
    logic rem;       // take right neighbor from pos up
    logic rep;       // write value at pos
    logic swp_even;  // odd-even transposition, even pairs
    logic swp_odd;
    logic desc;
  } cell_ctl_t;

endpackage

### hw/rtl/bounded_ordered_list_engine.sv
// top level of the bounded ordered list engine
//
// s_axis carries one command per transfer, m_axis one result per command.
// s_axis_tdata: op [3:0], position [8:4], operand_value [40:9], zero fill.
// m_axis_tdata: ok [0], read_value [32:1], found_index [37:33],
//   count_now [42:38], zero fill.
// entries sit in a row of DEPTH cells; insert, remove and sorted insert
// shift the cells from the insert or remove point up in parallel, replace
// writes one cell and select reads one cell. insert, remove, replace, select
// and sorted insert load the result register when accepted; search scans
// one cell per cycle up to the last entry; sort runs count odd-even transposition phases.
// one command is in flight at a time; s_axis_tready is low from the
// accepting edge until the result transfer completes.
// the result holds steady while m_axis_tready is low.
// reset empties the list; entry contents are left as they are.
module bounded_ordered_list_engine #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bole_pkg::TdInW-1:0]    s_axis_tdata,  // op, position, operand_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bole_pkg::TdOutW-1:0]   m_axis_tdata   // ok, read_value, found_index, count_now
);
  import bole_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH + 1);

  logic [OpW-1:0]        op;
  logic [PosW-1:0]       pos_raw;
  logic [ValW-1:0]       opv;
  logic [IdxW-1:0]       pos, c_pos, c_cnt, fnd, cnt;
  logic [DATA_WIDTH-1:0] val, c_val, rd;
  logic [DATA_WIDTH-1:0] cells [DEPTH];
  logic                  ok;
  cell_ctl_t             ctl;

  assign op      = s_axis_tdata[3:0];
  assign pos_raw = s_axis_tdata[8:4];
  assign opv     = s_axis_tdata[40:9];
  assign pos     = (IdxW >= PosW) ? IdxW'(pos_raw)
                 : ((pos_raw > PosW'(DEPTH)) ? IdxW'(DEPTH) : IdxW'(pos_raw));
  assign val     = DATA_WIDTH'($signed({{32{opv[ValW-1]}}, opv}));

  bole_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH), .IDX_W(IdxW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .op_i (op), .pos_i (pos), .val_i (val),
    .cells_i (cells),
    .ctl_o (ctl), .pos_o (c_pos), .cnt_o (c_cnt), .val_o (c_val),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .ok_o (ok), .rd_o (rd), .found_o (fnd), .count_o (cnt)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lft, rgt;
    assign lft = (g == 0) ? cells[0] : cells[(g == 0) ? 0 : g - 1];
    assign rgt = (g == DEPTH - 1) ? cells[DEPTH-1] : cells[(g == DEPTH - 1) ? g : g + 1];
    bole_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX_W(IdxW)) u_cell (
      .clk_i, .ctl_i (ctl), .idx_i (IdxW'(g)), .pos_i (c_pos), .cnt_i (c_cnt),
      .val_i (c_val), .left_i (lft), .right_i (rgt),
      .data_o (cells[g])
    );
  end

  assign m_axis_tdata = {5'd0, 5'(cnt), 5'(fnd),
                         32'(rd), ok};

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= IdxW'(DEPTH)) else $error("count above depth");
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
endmodule

### hw/rtl/bole_cell.sv
// one list cell: holds an entry and talks to its neighbors
module bole_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                    clk_i,
  input  bole_pkg::cell_ctl_t     ctl_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  logic [IDX_W-1:0]        pos_i,
  input  logic [IDX_W-1:0]        cnt_i,
  input  logic [DATA_WIDTH-1:0]   val_i,
  input  logic [DATA_WIDTH-1:0]   left_i,
  input  logic [DATA_WIDTH-1:0]   right_i,
  output logic [DATA_WIDTH-1:0]   data_o
);
  import bole_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  gt_left, gt_me, is_lo, is_hi, pair_ok_lo, pair_ok_hi;

  // order tests of this entry against the right neighbor and of the left neighbor against this entry, direction aware
  assign gt_me  = ctl_i.desc ? ($signed(data_q) < $signed(right_i))
                             : ($signed(data_q) > $signed(right_i));
  assign gt_left = ctl_i.desc ? ($signed(left_i) < $signed(data_q))
                              : ($signed(left_i) > $signed(data_q));
  assign is_lo = (idx_i[0] == (ctl_i.swp_odd ? 1'b1 : 1'b0));
  assign is_hi = !is_lo;
  assign pair_ok_lo = ({1'b0, idx_i} + 1'b1) < {1'b0, cnt_i};
  assign pair_ok_hi = (idx_i != '0) && (idx_i < cnt_i);

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (idx_i == pos_i) begin
        data_d = val_i;
      end else if (idx_i > pos_i) begin
        data_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (idx_i >= pos_i) begin
        data_d = right_i;
      end
    end else if (ctl_i.rep) begin
      if (idx_i == pos_i) begin
        data_d = val_i;
      end
    end else if (ctl_i.swp_even || ctl_i.swp_odd) begin
      if (is_lo && pair_ok_lo && gt_me) begin
        data_d = right_i;
      end else if (is_hi && pair_ok_hi && gt_left) begin
        data_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

### hw/rtl/bole_ctrl.sv
// command sequencer: decodes, runs sort passes and the search scan, holds the result
module bole_ctrl #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bole_pkg::OpW-1:0]   op_i,
  input  logic [IDX_W-1:0]           pos_i,
  input  logic [DATA_WIDTH-1:0]      val_i,
  input  logic [DATA_WIDTH-1:0]      cells_i [DEPTH],
  output bole_pkg::cell_ctl_t        ctl_o,
  output logic [IDX_W-1:0]           pos_o,
  output logic [IDX_W-1:0]           cnt_o,
  output logic [DATA_WIDTH-1:0]      val_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [DATA_WIDTH-1:0]      rd_o,
  output logic [IDX_W-1:0]           found_o,
  output logic [IDX_W-1:0]           count_o
);
  import bole_pkg::*;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d, step_q, step_d, fnd_q, fnd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d, rd_q, rd_d;
  logic                  ok_q, ok_d, desc_q, desc_d;
  logic                  acc, full, sorted_a, sorted_d, odd_q, odd_d;
  logic [IDX_W-1:0]      sel_idx, at_idx, last_idx;
  logic [IDX_W:0]        cnt_w;
  cell_ctl_t             ctl;
  logic [DEPTH-1:0]      gt_asc, gt_dsc, brk_a, brk_d, sgt_a, sgt_d;
  logic [DATA_WIDTH-1:0] scan;
  logic [IDX_W-1:0]      scan_idx;

  assign acc      = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign cnt_w    = {1'b0, cnt_q};
  assign full     = cnt_w >= (IDX_W+1)'(DEPTH);
  assign last_idx = cnt_q - 1'b1;

  // adjacent order violations and the sorted-insert point
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt_asc[i] = 1'b0;
      gt_dsc[i] = 1'b0;
      if (i + 1 < DEPTH) begin
        gt_asc[i] = $signed(cells_i[i]) > $signed(cells_i[i+1]);
        gt_dsc[i] = $signed(cells_i[i]) < $signed(cells_i[i+1]);
      end
      brk_a[i] = gt_asc[i] && ((i + 1) < int'(cnt_q));
      brk_d[i] = gt_dsc[i] && ((i + 1) < int'(cnt_q));
      sgt_a[i] = ($signed(cells_i[i]) >= $signed(val_i)) && (i < int'(cnt_q));
      sgt_d[i] = ($signed(cells_i[i]) <= $signed(val_i)) && (i < int'(cnt_q));
    end
  end
  assign sorted_a = (brk_a == '0);
  assign sorted_d = (brk_d == '0);

  always_comb begin
    at_idx = cnt_q;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((op_i == OP_SINS_DSC) ? sgt_d[i] : sgt_a[i]) begin
        at_idx = IDX_W'(i);
      end
    end
  end

  assign sel_idx = (pos_i >= last_idx) ? last_idx : pos_i;
  assign scan_idx = step_q;
  assign scan = cells_i[scan_idx[$clog2(DEPTH)-1:0]];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    fnd_d   = fnd_q;
    val_d   = val_q;
    rd_d    = rd_q;
    ok_d    = ok_q;
    desc_d  = desc_q;
    odd_d   = odd_q;
    ctl     = '0;
    ctl.desc = desc_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          ok_d  = 1'b0;
          rd_d  = '0;
          fnd_d = '0;
          val_d = val_i;
          state_d = ST_OUT;
          case (op_i)
            OP_INSERT: begin
              if (pos_i <= cnt_q && !full) begin
                ctl.ins = 1'b1;
                cnt_d = cnt_q + 1'b1;
                ok_d  = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pos_i < cnt_q) begin
                ctl.rem = 1'b1;
                cnt_d = cnt_q - 1'b1;
                ok_d  = 1'b1;
              end
            end
            OP_REPLACE: begin
              if (pos_i < cnt_q) begin
                ctl.rep = 1'b1;
                ok_d  = 1'b1;
              end
            end
            OP_SELECT: begin
              if (cnt_q != '0) begin
                rd_d = cells_i[sel_idx[$clog2(DEPTH)-1:0]];
                ok_d = 1'b1;
              end
            end
            OP_SEARCH: begin
              step_d  = '0;
              fnd_d   = cnt_q;
              state_d = (cnt_q == '0) ? ST_OUT : ST_SRCH;
            end
            OP_SINS_ASC, OP_SINS_DSC: begin
              if (((op_i == OP_SINS_DSC) ? sorted_d : sorted_a) && !full) begin
                ctl.ins = 1'b1;
                cnt_d = cnt_q + 1'b1;
                ok_d  = 1'b1;
              end
            end
            OP_SORT_ASC, OP_SORT_DSC: begin
              ok_d    = 1'b1;
              desc_d  = (op_i == OP_SORT_DSC);
              step_d  = cnt_q;
              odd_d   = 1'b0;
              state_d = (cnt_q > 1) ? ST_SORT : ST_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SORT: begin
        // odd-even transposition, cnt phases sort any order
        ctl.swp_even = !odd_q;
        ctl.swp_odd  = odd_q;
        odd_d  = !odd_q;
        step_d = step_q - 1'b1;
        if (step_q == 1) begin
          state_d = ST_OUT;
        end
      end
      ST_SRCH: begin
        if (scan == val_q) begin
          fnd_d   = step_q;
          ok_d    = 1'b1;
          state_d = ST_OUT;
        end else if (step_q == last_idx) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (acc && (op_i == OP_SINS_ASC || op_i == OP_SINS_DSC)) begin
      ctl.desc = (op_i == OP_SINS_DSC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      odd_q   <= 1'b0;
      desc_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      odd_q   <= odd_d;
      desc_q  <= desc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
    ok_q  <= ok_d;
    fnd_q <= fnd_d;
  end

  assign ctl_o       = ctl;
  assign pos_o       = (acc && (op_i == OP_SINS_ASC || op_i == OP_SINS_DSC)) ? at_idx : pos_i;
  assign cnt_o       = cnt_q;
  assign val_o       = val_i;
  assign out_valid_o = (state_q == ST_OUT);
  assign ok_o        = ok_q;
  assign rd_o        = rd_q;
  assign found_o     = fnd_q;
  assign count_o     = cnt_q;
endmodule

### tb/sv/bounded_ordered_list_engine_tb.sv
// testbench for the bounded ordered list engine: directed and random command streams checked against a predictor
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [4:0]  count_now;
    logic [4:0]  found_index;
    logic [31:0] read_value;
    logic        ok;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] cells[Depth];
    int unsigned        used;
    list_result_t       pending[$];
    int                 mismatches;

    function new();
      used = 0;
      mismatches = 0;
      for (int i = 0; i < Depth; i++) cells[i] = '0;
    endfunction

    function bit is_sorted(bit desc);
      for (int i = 0; i + 1 < used; i++)
        if (desc ? (cells[i] < cells[i+1]) : (cells[i] > cells[i+1])) return 0;
      return 1;
    endfunction

    function bit place(int unsigned idx, logic signed [31:0] v);
      if (idx > used || used >= Depth) return 0;
      for (int i = used; i > idx; i--) cells[i] = cells[i-1];
      cells[idx] = v;
      used++;
      return 1;
    endfunction

    function void order_cells(bit desc);
      logic signed [31:0] t;
      for (int p = 0; p + 1 < used; p++)
        for (int i = 0; i + 1 < used; i++)
          if (desc ? (cells[i] < cells[i+1]) : (cells[i] > cells[i+1])) begin
            t = cells[i]; cells[i] = cells[i+1]; cells[i+1] = t;
          end
    endfunction

    function void note_command(logic [3:0] op, logic [4:0] pos, logic signed [31:0] v);
      list_result_t r;
      int unsigned at;
      bit desc;
      r = '0;
      case (op)
        OP_INSERT: r.ok = place(pos, v);
        OP_REMOVE: begin
          if (pos < used) begin
            for (int i = pos; i + 1 < used; i++) cells[i] = cells[i+1];
            used--;
            r.ok = 1;
          end
        end
        OP_REPLACE: begin
          if (pos < used) begin
            cells[pos] = v;
            r.ok = 1;
          end
        end
        OP_SELECT: begin
          if (used > 0) begin
            r.read_value = cells[(pos >= used - 1) ? used - 1 : pos];
            r.ok = 1;
          end
        end
        OP_SEARCH: begin
          r.found_index = 5'(used);
          for (int i = 0; i < used; i++)
            if (cells[i] == v) begin
              r.found_index = 5'(i);
              r.ok = 1;
              break;
            end
        end
        OP_SINS_ASC, OP_SINS_DSC: begin
          desc = (op == OP_SINS_DSC);
          if (is_sorted(desc) && used < Depth) begin
            at = used;
            for (int i = 0; i < used; i++)
              if (desc ? (cells[i] <= v) : (cells[i] >= v)) begin
                at = i;
                break;
              end
            r.ok = place(at, v);
          end
        end
        OP_SORT_ASC: begin order_cells(0); r.ok = 1; end
        OP_SORT_DSC: begin order_cells(1); r.ok = 1; end
        default: ;
      endcase
      r.count_now = 5'(used);
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp ok=%0d rd=%h idx=%0d cnt=%0d %s ok=%0d rd=%h idx=%0d cnt=%0d",
                   exp.ok, exp.read_value, exp.found_index, exp.count_now, "got",
                   got.ok, got.read_value, got.found_index, got.count_now);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;

  list_scoreboard board = new();
  bit          quiet = 0;
  int unsigned hold_cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  bounded_ordered_list_engine i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      board.note_command(s_axis_tdata[3:0], s_axis_tdata[8:4], s_axis_tdata[40:9]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata[42:0]);
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  function logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(20)) - 10;
    endcase
  endfunction

  // tvalid stays high into a back-to-back transfer and drops only on a gap
  task automatic send_command(logic [3:0] op, logic [4:0] pos, logic signed [31:0] v);
    while (!quiet && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {7'b0, v, pos, op};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [3:0] op;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed
    send_command(OP_SELECT, 0, 1);
    send_command(OP_SEARCH, 0, 1);
    send_command(OP_REMOVE, 0, 0);
    send_command(OP_SORT_ASC, 0, 0);
    send_command(OP_INSERT, 1, 5);
    send_command(OP_INSERT, 0, 32'sh7fff_ffff);
    send_command(OP_INSERT, 1, 32'sh8000_0000);
    send_command(OP_SINS_ASC, 0, 3);
    send_command(OP_SORT_ASC, 0, 0);
    send_command(OP_SINS_ASC, 0, 3);
    send_command(OP_SINS_DSC, 0, 3);
    send_command(OP_SORT_DSC, 0, 0);
    send_command(OP_SINS_DSC, 0, 3);
    send_command(OP_SELECT, 31, 0);
    send_command(OP_SEARCH, 0, 99);
    send_command(OP_SEARCH, 0, 3);
    send_command(OP_REPLACE, 2, -7);
    send_command(OP_REPLACE, 9, 1);
    send_command(4'd15, 31, -1);
    send_command(4'd9, 16, 0);
    for (int i = 0; i < 14; i++) send_command(OP_INSERT, 0, pick_value());
    send_command(OP_INSERT, 0, 1);
    send_command(OP_SINS_ASC, 0, 1);
    // sender pause until idle
    drain();
    // receiver holds off while commands keep coming
    hold_cycles = 200;
    for (int n = 0; n < 2000; n++) begin
      if (n == 1000) quiet = 1;
      if (n == 1300) quiet = 0;
      if ($urandom_range(99) < 3) op = 4'($urandom_range(15, 9));
      else op = 4'($urandom_range(8));
      if ((op == OP_SORT_ASC || op == OP_SORT_DSC) && $urandom_range(3) != 0) op = OP_SELECT;
      send_command(op, (($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(16))),
                   pick_value());
      if (n == 600) drain();
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("[bounded_ordered_list_engine] OK");
    else
      $display("[bounded_ordered_list_engine] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[bounded_ordered_list_engine] ERROR");
    $finish;
  end

endmodule
